// ===== design/sra_pkg.sv =====
// shared types, character constants and helpers for the signed radix to ascii block
// no dependencies; used by signed_radix_to_ascii_top
package sra_pkg;

  // alphabet register file
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_INDEX_W = 4;
  localparam int ALPHA_BYTES = 64;
  localparam int BYTE_IDX_W  = 6;

  // long division bits retired per cycle
  localparam int DIV_STEPS = 8;

  // ascii codes
  localparam logic [7:0] CH_DIGIT_LO = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;
  localparam logic [7:0] CH_UPPER_LO = 8'd65;
  localparam logic [7:0] CH_UPPER_HI = 8'd90;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_MINUS    = 8'd45;
  localparam logic [7:0] CH_NUL      = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } state_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
           (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
  endfunction

endpackage

// ===== design/signed_radix_to_ascii_top.sv =====
// signed number to text converter with a configurable digit alphabet
// depends on sra_pkg (state type, ascii constants, alphabet helpers)
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------
//  in      | sink      | in_valid / in_stall  | value
//  out     | source    | out_valid / out_stall| text_char, final_char
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// each digit of an item comes from the long division loop, which retires 8
// quotient bits a cycle; a negative item prints a minus sign first, and each
// digit character goes through the registered read of the digit buffer.
// cfg_ready is low while an item is divided or printed; in_stall is high during
// a config beat and while the alphabet is checked one character a cycle (a new
// config beat restarts the check); reset leaves an empty (invalid) alphabet, so
// items are taken and dropped until one is written.
// out_stall holds the output register and any load behind it; the next item is taken
// while the last character of the previous one still waits.
module signed_radix_to_ascii_top #(
  parameter int VALUE_WIDTH  = 32,
  parameter int ALPHABET_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // item input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_WIDTH-1:0]   value,
  // character output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      text_char,
  output logic                            final_char,
  // alphabet register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sra_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  localparam int STEPS   = sra_pkg::DIV_STEPS;
  localparam int NCHUNK  = (VALUE_WIDTH + STEPS - 1) / STEPS;
  localparam int W_PAD   = NCHUNK * STEPS;
  localparam int CHUNK_W = $clog2(NCHUNK + 1);
  localparam int RADIX_W = $clog2(ALPHABET_MAX + 1);
  localparam int DIGIT_W = $clog2(ALPHABET_MAX);
  localparam int ND_W    = $clog2(VALUE_WIDTH + 1);
  localparam int MIDX_W  = $clog2(VALUE_WIDTH);
  localparam int BIW     = sra_pkg::BYTE_IDX_W;
  localparam int CIW     = sra_pkg::CFG_INDEX_W;
  localparam int RIW     = sra_pkg::REG_IDX_W;

  // ---------------------------------------------------------------
  // alphabet registers and their byte view
  // ---------------------------------------------------------------
  logic [63:0] alpha_regs [sra_pkg::NUM_REGS];
  logic [7:0]  alpha_bytes [sra_pkg::ALPHA_BYTES];

  for (genvar b = 0; b < sra_pkg::ALPHA_BYTES; b++) begin : g_bytes
    assign alpha_bytes[b] = alpha_regs[b / 8][(b % 8) * 8 +: 8];
  end

  sra_pkg::state_t state, state_next;

  // alphabet writes only between items
  logic cfg_we;
  assign cfg_ready = (state == sra_pkg::ST_IDLE) || (state == sra_pkg::ST_CHECK);
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < sra_pkg::NUM_REGS; r++) begin
        alpha_regs[r] <= '0;
      end
    end else if (cfg_we && cfg_index < CIW'(sra_pkg::NUM_REGS)) begin
      alpha_regs[cfg_index[RIW-1:0]] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------
  // state and datapath registers
  // ---------------------------------------------------------------
  logic [RADIX_W-1:0] chk_cnt;     // character under check
  logic               alpha_ok;    // alphabet passed all checks
  logic [RADIX_W-1:0] radix;       // alphabet length
  logic               neg;         // current item is negative
  logic [W_PAD-1:0]   num;         // numerator, quotient shifts in at the bottom
  logic [RADIX_W-1:0] rem;         // partial remainder
  logic [CHUNK_W-1:0] chunk;       // division chunk counter
  logic [ND_W-1:0]    nd;          // digits stored / digits left to send
  logic [DIGIT_W-1:0] rd_data;     // registered digit buffer read

  logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

  // ---------------------------------------------------------------
  // shared alphabet byte read: checker index or digit to print
  // ---------------------------------------------------------------
  logic [BIW-1:0] byte_idx;
  logic [7:0]     byte_rd;

  assign byte_idx = (state == sra_pkg::ST_CHECK) ? BIW'(chk_cnt) : BIW'(rd_data);
  assign byte_rd  = alpha_bytes[byte_idx];

  // check of one character against every earlier one
  logic chk_end, chk_bad, chk_dup;

  always_comb begin
    chk_dup = 1'b0;
    for (int j = 0; j < sra_pkg::ALPHA_BYTES; j++) begin
      if (j < int'(chk_cnt) && alpha_bytes[j] == byte_rd) begin
        chk_dup = 1'b1;
      end
    end
  end

  assign chk_end = (chk_cnt == RADIX_W'(ALPHABET_MAX)) || (byte_rd == sra_pkg::CH_NUL);
  assign chk_bad = !sra_pkg::is_alnum(byte_rd) || chk_dup;

  // ---------------------------------------------------------------
  // magnitude of the incoming value
  // ---------------------------------------------------------------
  logic [VALUE_WIDTH-1:0] v_u, mag;

  assign v_u = value;
  assign mag = v_u[VALUE_WIDTH-1] ? VALUE_WIDTH'(~v_u + 1'b1) : v_u;

  // ---------------------------------------------------------------
  // shared divide unit: eight restoring long division steps
  // ---------------------------------------------------------------
  logic [W_PAD-1:0]   num_step;
  logic [RADIX_W-1:0] rem_step;

  always_comb begin
    logic [W_PAD-1:0]   n_t;
    logic [RADIX_W:0]   r_t;
    logic [RADIX_W-1:0] r_s;
    n_t = num;
    r_s = rem;
    r_t = '0;
    for (int s = 0; s < STEPS; s++) begin
      r_t = {r_s, n_t[W_PAD-1]};
      n_t = {n_t[W_PAD-2:0], 1'b0};
      if (r_t >= {1'b0, radix}) begin
        r_t    = r_t - {1'b0, radix};
        n_t[0] = 1'b1;
      end
      r_s = r_t[RADIX_W-1:0];
    end
    num_step = n_t;
    rem_step = r_s;
  end

  logic last_chunk, quot_zero;
  assign last_chunk = (chunk == CHUNK_W'(NCHUNK - 1));
  assign quot_zero  = (num_step == '0);

  logic [ND_W-1:0] nd_m1;
  logic            nd_last;
  assign nd_m1   = nd - ND_W'(1);
  assign nd_last = (nd == ND_W'(1));

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      sra_pkg::ST_IDLE: begin
        if (cfg_we) begin
          state_next = sra_pkg::ST_CHECK;
        end else if (in_valid && alpha_ok) begin
          state_next = sra_pkg::ST_DIV;
        end
      end
      sra_pkg::ST_CHECK: begin
        if (cfg_we) begin
          state_next = sra_pkg::ST_CHECK;
        end else if (chk_end || chk_bad) begin
          state_next = sra_pkg::ST_IDLE;
        end
      end
      sra_pkg::ST_DIV: begin
        if (last_chunk && quot_zero) begin
          state_next = neg ? sra_pkg::ST_SIGN : sra_pkg::ST_READ;
        end
      end
      sra_pkg::ST_SIGN: begin
        if (out_free) begin
          state_next = sra_pkg::ST_READ;
        end
      end
      sra_pkg::ST_READ: begin
        state_next = sra_pkg::ST_LOAD;
      end
      sra_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = nd_last ? sra_pkg::ST_IDLE : sra_pkg::ST_READ;
        end
      end
      default: begin
        state_next = sra_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // sequencer: control outputs
  // ---------------------------------------------------------------
  logic chk_start, chk_step, chk_done, take, div_run, dig_we, rd_en;
  logic load_sign, load_digit;

  always_comb begin
    in_stall   = 1'b1;
    chk_start  = 1'b0;
    chk_step   = 1'b0;
    chk_done   = 1'b0;
    take       = 1'b0;
    div_run    = 1'b0;
    dig_we     = 1'b0;
    rd_en      = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state)
      sra_pkg::ST_IDLE: begin
        // a config beat holds off the item so it is not lost
        in_stall  = cfg_we;
        chk_start = cfg_we;
        take      = in_valid && !cfg_we;
      end
      sra_pkg::ST_CHECK: begin
        chk_start = cfg_we;
        chk_done  = !cfg_we && (chk_end || chk_bad);
        chk_step  = !cfg_we && !chk_end && !chk_bad;
      end
      sra_pkg::ST_DIV: begin
        div_run = 1'b1;
        dig_we  = last_chunk;
      end
      sra_pkg::ST_SIGN: begin
        load_sign = out_free;
      end
      sra_pkg::ST_READ: begin
        rd_en = 1'b1;
      end
      sra_pkg::ST_LOAD: begin
        load_digit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sra_pkg::ST_IDLE;
      alpha_ok  <= 1'b0;
      radix     <= '0;
      chk_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // alphabet check
      if (chk_start) begin
        chk_cnt  <= '0;
        alpha_ok <= 1'b0;
      end else if (chk_step) begin
        chk_cnt <= chk_cnt + RADIX_W'(1);
      end else if (chk_done) begin
        radix    <= chk_cnt;
        alpha_ok <= chk_end && (chk_cnt >= RADIX_W'(2));
      end

      // output register
      if (load_sign || load_digit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      neg   <= v_u[VALUE_WIDTH-1];
      num   <= W_PAD'(mag);
      rem   <= '0;
      chunk <= '0;
      nd    <= '0;
    end else if (div_run) begin
      if (last_chunk) begin
        num   <= num_step;
        rem   <= '0;
        chunk <= '0;
        nd    <= nd + ND_W'(1);
      end else begin
        num   <= num_step;
        rem   <= rem_step;
        chunk <= chunk + CHUNK_W'(1);
      end
    end else if (load_digit) begin
      nd <= nd_m1;
    end

    if (load_sign) begin
      text_char  <= sra_pkg::CH_MINUS;
      final_char <= 1'b0;
    end else if (load_digit) begin
      text_char  <= byte_rd;
      final_char <= nd_last;
    end
  end

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (dig_we) begin
      digit_mem[nd[MIDX_W-1:0]] <= DIGIT_W'(rem_step);
    end
    if (rd_en) begin
      rd_data <= digit_mem[nd_m1[MIDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_div_needs_alphabet : assert property (@(posedge clk) disable iff (rst)
    (state == sra_pkg::ST_DIV) |-> alpha_ok)
    else $error("division running with an invalid alphabet");

  a_rem_below_radix : assert property (@(posedge clk) disable iff (rst)
    (state == sra_pkg::ST_DIV) |-> (rem < radix))
    else $error("partial remainder not below radix");

  a_digit_count : assert property (@(posedge clk) disable iff (rst)
    (state == sra_pkg::ST_DIV) |-> (nd < ND_W'(VALUE_WIDTH)))
    else $error("digit buffer overflow");

  a_last_ends_item : assert property (@(posedge clk) disable iff (rst)
    (load_digit && nd_last) |=> (state == sra_pkg::ST_IDLE) && final_char)
    else $error("last digit did not end the item");

  a_out_from_load : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == sra_pkg::ST_SIGN ||
                          $past(state) == sra_pkg::ST_LOAD))
    else $error("output beat raised outside a load");

endmodule
